// ===== rtl/core/sdu_pkg.sv =====
// Shared types and constants for the diagonal-update block.
// Used by sdu_ctrl, sdu_div, sdu_dp and sse_diagonal_update_top; no dependencies.
package sdu_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int MAX_SITES = 256;
  localparam int SITE_AW   = $clog2(MAX_SITES);

  // field widths
  localparam int CODE_W  = 11;
  localparam int CNT_W   = 11;
  localparam int DIM_W   = 2;
  localparam int LEN_W   = 9;
  localparam int CUT_W   = 11;
  localparam int BETA_W  = 24;
  localparam int WGT_W   = 20;
  localparam int RB_W    = 9;
  localparam int RU_W    = 16;
  localparam int BOND_W  = 10;
  localparam int NS_W    = 18;   // site count, up to 511*511
  localparam int NB_W    = 19;   // bond count
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 24;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 32;
  localparam int DIV_STEPS = BOND_W;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_DIM    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_LEN    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_CUTOFF = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BETA   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_W_UP   = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_W_ANTI = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_W_DOWN = 3'd6;

  localparam logic [DIM_W-1:0] DIM_SQUARE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic take;     // latch input item
    logic clr;      // clear one slot entry
    logic load;     // write loaded spin
    logic rd;       // read slot entry
    logic dec;      // decode slot code, start divider
    logic div_step; // one divider step
    logic sites;    // compute bond endpoints
    logic spin;     // read both spins
    logic mul1;     // beta * weight
    logic mul2;     // partial products with bond count
    logic mul3;     // sum the partial products
    logic mul4;     // products with r
    logic cmp;      // decide and update
    logic flip0;    // flip first spin
    logic flip1;    // flip second spin
    logic fin;      // load output register, advance pointer
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_load;
    logic bad;
    logic off_diag;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/sdu_ctrl.sv =====
// Controller state machine for the diagonal update.
// Depends on sdu_pkg (cmd_t, status_t).
module sdu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdu_pkg::status_t st,
  output sdu_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_READ, S_DECODE, S_DIVIDE, S_SITES, S_SPIN,
    S_WEIGHT, S_MUL2, S_MUL3, S_MUL4, S_COMPARE, S_FLIP0, S_FLIP1, S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.take     = (state == S_IDLE) && in_valid;
    cmd.clr      = (state == S_CLEAR);
    cmd.load     = (state == S_LOAD);
    cmd.rd       = (state == S_READ);
    cmd.dec      = (state == S_DECODE);
    cmd.div_step = (state == S_DIVIDE);
    cmd.sites    = (state == S_SITES);
    cmd.spin     = (state == S_SPIN);
    cmd.mul1     = (state == S_WEIGHT);
    cmd.mul2     = (state == S_MUL2);
    cmd.mul3     = (state == S_MUL3);
    cmd.mul4     = (state == S_MUL4);
    cmd.cmp      = (state == S_COMPARE);
    cmd.flip0    = (state == S_FLIP0);
    cmd.flip1    = (state == S_FLIP1);
    cmd.fin      = (state == S_FINISH) && st.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:   if (st.clr_last) state <= S_IDLE;
        S_IDLE:    if (in_valid) state <= st.is_load ? S_LOAD : S_READ;
        S_LOAD:    state <= S_FINISH;
        S_READ:    state <= S_DECODE;
        S_DECODE:  state <= st.bad ? S_FINISH : S_DIVIDE;
        S_DIVIDE:  if (st.div_last) state <= S_SITES;
        S_SITES:   state <= S_SPIN;
        S_SPIN:    state <= S_WEIGHT;
        S_WEIGHT:  state <= st.off_diag ? S_FLIP0 : S_MUL2;
        S_MUL2:    state <= S_MUL3;
        S_MUL3:    state <= S_MUL4;
        S_MUL4:    state <= S_COMPARE;
        S_COMPARE: state <= S_FINISH;
        S_FLIP0:   state <= S_FLIP1;
        S_FLIP1:   state <= S_FINISH;
        S_FINISH:  if (st.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sdu_div.sv =====
// Restoring divider, one quotient bit per step; only the remainder is kept.
// Depends on sdu_pkg for widths.
module sdu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [sdu_pkg::BOND_W-1:0]  dividend,
  input  logic [sdu_pkg::LEN_W-1:0]   divisor,
  output logic [sdu_pkg::LEN_W-1:0]   remainder,
  output logic                        last
);

  localparam int CW = $clog2(sdu_pkg::DIV_STEPS + 1);

  logic [sdu_pkg::BOND_W-1:0] dvd;
  logic [sdu_pkg::LEN_W-1:0]  rem;
  logic [CW-1:0]              cnt;
  logic [sdu_pkg::LEN_W:0]    rem_sh;
  logic [sdu_pkg::LEN_W:0]    rem_sub;

  assign rem_sh    = {rem, dvd[sdu_pkg::BOND_W-1]};
  assign rem_sub   = rem_sh - {1'b0, divisor};
  assign remainder = rem;
  assign last      = (cnt == CW'(sdu_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // shift and conditional subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (step) begin
      dvd <= {dvd[sdu_pkg::BOND_W-2:0], 1'b0};
      rem <= (rem_sh >= {1'b0, divisor}) ? rem_sub[sdu_pkg::LEN_W-1:0]
                                          : rem_sh[sdu_pkg::LEN_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sdu_dp.sv =====
// Datapath: configuration, slot and spin stores, bond geometry, products.
// Depends on sdu_pkg and instantiates sdu_div.
module sdu_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sdu_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [sdu_pkg::CFG_DW-1:0]  cfg_data,
  input  logic [sdu_pkg::IN_DW-1:0]   in_data,
  input  logic                        in_user,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sdu_pkg::OUT_DW-1:0]  out_data,
  input  sdu_pkg::cmd_t               cmd,
  output sdu_pkg::status_t            st
);

  // configuration registers
  logic [sdu_pkg::DIM_W-1:0]  dim;
  logic [sdu_pkg::LEN_W-1:0]  len;
  logic [sdu_pkg::CUT_W-1:0]  cutoff;
  logic [sdu_pkg::BETA_W-1:0] beta;
  logic [sdu_pkg::WGT_W-1:0]  w_up, w_anti, w_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim    <= 2'd1;
      len    <= 9'd16;
      cutoff <= 11'd4;
      beta   <= 24'd65536;
      w_up   <= '0;
      w_anti <= 20'd32768;
      w_down <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdu_pkg::CFG_DIM:    dim    <= cfg_data[sdu_pkg::DIM_W-1:0];
        sdu_pkg::CFG_LEN:    len    <= cfg_data[sdu_pkg::LEN_W-1:0];
        sdu_pkg::CFG_CUTOFF: cutoff <= cfg_data[sdu_pkg::CUT_W-1:0];
        sdu_pkg::CFG_BETA:   beta   <= cfg_data[sdu_pkg::BETA_W-1:0];
        sdu_pkg::CFG_W_UP:   w_up   <= cfg_data[sdu_pkg::WGT_W-1:0];
        sdu_pkg::CFG_W_ANTI: w_anti <= cfg_data[sdu_pkg::WGT_W-1:0];
        sdu_pkg::CFG_W_DOWN: w_down <= cfg_data[sdu_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  logic dim2;
  assign dim2 = (dim == sdu_pkg::DIM_SQUARE);

  // effective cutoff: saturate high, zero acts as one
  logic [sdu_pkg::CUT_W-1:0] m_eff;
  always_comb begin
    if (cutoff > sdu_pkg::CUT_W'(sdu_pkg::MAX_SLOTS)) m_eff = sdu_pkg::CUT_W'(sdu_pkg::MAX_SLOTS);
    else if (cutoff == '0) m_eff = sdu_pkg::CUT_W'(1);
    else m_eff = cutoff;
  end

  // input item latch
  logic                       op_q;
  logic [sdu_pkg::RB_W-1:0]   rb_q;
  logic [sdu_pkg::RU_W-1:0]   ru_q;
  logic [sdu_pkg::SITE_AW-1:0] si_q;
  logic                       sv_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q <= in_user;
      rb_q <= in_data[8:0];
      ru_q <= in_data[24:9];
      si_q <= in_data[32:25];
      sv_q <= in_data[33];
    end
  end

  // control state: pointer, count, clear address, output valid
  logic [sdu_pkg::SLOT_AW-1:0] ptr, clr_addr, p_q;
  logic [sdu_pkg::CNT_W-1:0]   count;
  logic                        sweep_end;

  assign sweep_end = ({1'b0, p_q} == m_eff - 1'b1);

  // slot store
  logic [sdu_pkg::CODE_W-1:0]  slot_mem [sdu_pkg::MAX_SLOTS];
  logic [sdu_pkg::CODE_W-1:0]  code_q;
  logic                        slot_we;
  logic [sdu_pkg::SLOT_AW-1:0] slot_wa;
  logic [sdu_pkg::CODE_W-1:0]  slot_wd;
  logic [sdu_pkg::SLOT_AW-1:0] p_c;

  assign p_c = ({1'b0, ptr} >= m_eff) ? '0 : ptr;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.rd) code_q <= slot_mem[p_c];
  end

  // lattice sizes, registered at the slot read
  logic [sdu_pkg::NS_W-1:0] n_q;
  logic [sdu_pkg::NB_W-1:0] nb_q;
  logic [sdu_pkg::NS_W-1:0] n_c;

  assign n_c = dim2 ? sdu_pkg::NS_W'(len * len) : sdu_pkg::NS_W'(len);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      p_q  <= p_c;
      n_q  <= n_c;
      nb_q <= dim2 ? {n_c, 1'b0} : {1'b0, n_c};
    end
  end

  // decode of the visited slot
  logic [sdu_pkg::BOND_W-1:0] bond_c, bred_c, bond_q, bred_q;
  logic                       bad_c, hi_c, empty_q, odd_q, hi_q;
  logic                       stat_q, acc_q;
  logic [sdu_pkg::CODE_W-1:0] res_code;

  always_comb begin
    bond_c = (code_q == '0) ? {1'b0, rb_q} : (code_q[sdu_pkg::CODE_W-1:1] - 1'b1);
    bad_c  = (code_q == sdu_pkg::CODE_W'(1)) ||
             ({{(sdu_pkg::NB_W-sdu_pkg::BOND_W){1'b0}}, bond_c} >= nb_q);
    hi_c   = dim2 && ({{(sdu_pkg::NS_W-sdu_pkg::BOND_W){1'b0}}, bond_c} >= n_q);
    bred_c = hi_c ? (bond_c - n_q[sdu_pkg::BOND_W-1:0]) : bond_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.dec) begin
      bond_q  <= bond_c;
      bred_q  <= bred_c;
      hi_q    <= hi_c;
      empty_q <= (code_q == '0);
      odd_q   <= code_q[0];
    end
  end

  // column remainder for the square lattice
  logic [sdu_pkg::LEN_W-1:0] col;
  logic                      div_last;

  sdu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.dec),
    .step      (cmd.div_step),
    .dividend  (bred_c),
    .divisor   (len),
    .remainder (col),
    .last      (div_last)
  );

  // bond endpoints
  logic [sdu_pkg::SITE_AW-1:0] s0_q, s1_q;
  logic [sdu_pkg::NS_W:0]      nxt, wrap, c_c;

  always_comb begin
    nxt  = sdu_pkg::NS_W'(bred_q) + 1'b1;
    wrap = '0;
    c_c  = '0;
    if (!dim2) begin
      c_c = (nxt == {1'b0, n_q}) ? '0 : nxt;
    end else if (!hi_q) begin
      c_c = ({1'b0, col} + 1'b1 == {1'b0, len}) ? nxt - len : nxt;
    end else begin
      wrap = sdu_pkg::NS_W'(bred_q) + len;
      c_c  = (wrap >= {1'b0, n_q}) ? wrap - n_q : wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sites) begin
      s0_q <= bred_q[sdu_pkg::SITE_AW-1:0];
      s1_q <= c_c[sdu_pkg::SITE_AW-1:0];
    end
  end

  // spin store, unwritten sites read as up
  logic                        spin_mem [sdu_pkg::MAX_SITES];
  logic [sdu_pkg::MAX_SITES-1:0] spin_vld;
  logic                        spin_we, spin_wd;
  logic [sdu_pkg::SITE_AW-1:0] spin_wa;
  logic                        r0, r1, v0, v1, sp0, sp1;

  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_wa] <= spin_wd;
    if (cmd.spin) begin
      r0 <= spin_mem[s0_q];
      r1 <= spin_mem[s1_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_vld <= '0;
    end else if (spin_we) begin
      spin_vld[spin_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spin) begin
      v0 <= spin_vld[s0_q];
      v1 <= spin_vld[s1_q];
    end
  end

  assign sp0 = v0 ? r0 : 1'b1;
  assign sp1 = v1 ? r1 : 1'b1;

  // a bond whose ends land on one site would flip it twice, so it is not written
  always_comb begin
    spin_we = cmd.load || ((cmd.flip0 || cmd.flip1) && (s1_q != s0_q));
    spin_wa = cmd.load ? si_q : (cmd.flip0 ? s0_q : s1_q);
    spin_wd = cmd.load ? sv_q : (cmd.flip0 ? ~sp0 : ~sp1);
  end

  // product chain: beta*w, then *bond count, then *r
  logic [sdu_pkg::WGT_W-1:0] wsel;
  logic [43:0] m1_q;
  logic [40:0] xl_q, xh_q;
  logic [63:0] x_q;
  logic [47:0] ul_q, uh_q;
  logic [42:0] ins_q;
  logic signed [sdu_pkg::CNT_W:0] room;

  assign wsel = (sp0 != sp1) ? w_anti : (sp0 ? w_up : w_down);
  assign room = $signed({1'b0, m_eff}) - $signed({1'b0, count});

  always_ff @(posedge clk) begin
    if (cmd.mul1) m1_q <= beta * wsel;
    if (cmd.mul2) begin
      xl_q <= m1_q[21:0] * nb_q;
      xh_q <= m1_q[43:22] * nb_q;
    end
    if (cmd.mul3) x_q <= {xh_q, 22'd0} + {23'd0, xl_q};
    if (cmd.mul4) begin
      ul_q  <= x_q[31:0] * ru_q;
      uh_q  <= x_q[63:32] * ru_q;
      ins_q <= {27'(ru_q) * 27'(room[sdu_pkg::CNT_W-1:0]), 16'd0};
    end
  end

  // acceptance tests
  logic [79:0] ux;
  logic signed [sdu_pkg::CNT_W+1:0] rr;
  logic ins_ok, rem_ok;

  always_comb begin
    ux     = {uh_q, 32'd0} + {32'd0, ul_q};
    rr     = room + 2'sd1;
    ins_ok = (room <= 0) || ({21'd0, ins_q} <= x_q);
    rem_ok = !rr[sdu_pkg::CNT_W+1] &&
             (ux <= {20'd0, rr[sdu_pkg::CNT_W:0], 48'd0});
  end

  // slot write port: clear pass or update
  always_comb begin
    slot_we = cmd.clr || (cmd.cmp && (empty_q ? ins_ok : rem_ok));
    slot_wa = cmd.clr ? clr_addr : p_q;
    slot_wd = (cmd.clr || !empty_q) ? '0 : {bond_q + 1'b1, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      stat_q <= 1'b0;
      acc_q  <= 1'b0;
    end else if (cmd.dec) begin
      stat_q   <= bad_c;
      res_code <= code_q;
    end else if (cmd.cmp && slot_we) begin
      acc_q    <= 1'b1;
      res_code <= slot_wd;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.cmp && slot_we) count <= empty_q ? count + 1'b1 : count - 1'b1;
      if (cmd.fin && !op_q) ptr <= sweep_end ? '0 : p_q + 1'b1;
      if (cmd.fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data <= {7'd0, !op_q && stat_q, !op_q && sweep_end, !op_q && acc_q,
                   count, op_q ? '0 : res_code};
    end
  end

  // status
  always_comb begin
    st          = '0;
    st.clr_last = (clr_addr == sdu_pkg::SLOT_AW'(sdu_pkg::MAX_SLOTS - 1));
    st.is_load  = in_user;
    st.bad      = bad_c;
    st.off_diag = !empty_q && odd_q;
    st.div_last = div_last;
    st.out_free = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/sse_diagonal_update_top.sv =====
// Diagonal update of an operator string: one slot visited, or one spin
// loaded, for each transfer in; one result per transfer. After reset a
// clearing pass empties all 1024 slots before the first item is accepted.
// A spin load writes the spin store and goes to the result; a slot whose
// bond is out of range stops after decode; an off-diagonal slot passes the
// 10-step divider for the lattice column, the bond endpoints and the spin
// read, then flips both spins; an empty or diagonal slot passes the divider
// and the product chain for u * beta * bonds * weight. One item is worked
// at a time; the next is accepted while a result waits at the output. The
// user must write configuration only while idle; the block does not enforce it.
// Depends on sdu_pkg; instantiates sdu_ctrl and sdu_dp.
module sse_diagonal_update_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sdu_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [sdu_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // rand_bond[8:0], rand_uniform[24:9], site_index[32:25], spin_value[33]
  input  logic [sdu_pkg::IN_DW-1:0]   s_axis_tdata,
  // operation
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // slot_code[10:0], op_count[21:11], accepted[22], sweep_done[23], status[24]
  output logic [sdu_pkg::OUT_DW-1:0]  m_axis_tdata
);

  sdu_pkg::cmd_t    cmd;
  sdu_pkg::status_t st;

  sdu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sdu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
